### design/sinf_pkg.sv
// ----------------------------------------------------------------------------
// sinf_pkg
// Shared types and constants of the stereo notch filter: widths, register
// indexes, sequencer states and the control structs between its modules.
// ----------------------------------------------------------------------------
package sinf_pkg;

	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int COEF_FRAC_DEF    = 30;
	localparam int COEF_WIDTH       = 31;
	localparam int CFG_INDEX_WIDTH  = 2;
	localparam int MUL_A_WIDTH      = 32;
	localparam int DIGIT_WIDTH      = 16;
	localparam int CLAMP_EXP        = 60;
	localparam int RES_WIDTH        = CLAMP_EXP + 2;

	localparam longint ALPHA_RESET_Q30 = 780119607;
	localparam longint BETA_RESET_Q30  = 1073739354;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_ALPHA = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BETA  = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_COMMIT,
		ST_PUSH
	} seq_state_t;

	typedef enum logic [2:0] {
		OP_CF,
		OP_P1,
		OP_T1,
		OP_T2,
		OP_T3
	} mac_op_t;

	typedef struct packed {
		logic    in_ready;
		logic    mac_start;
		logic    capture;
		logic    commit;
		logic    push;
		mac_op_t op;
		logic    chan;
	} seq_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mac_stat_t;

endpackage

### design/sinf_mac.sv
// ----------------------------------------------------------------------------
// sinf_mac
// Shared multiplier: a 32-bit operand times a wide operand, one 16-bit digit
// of the wide operand per cycle, then round to nearest and clamp.
// ----------------------------------------------------------------------------
module sinf_mac import sinf_pkg::*; #(
	parameter int B_WIDTH   = 3 * DIGIT_WIDTH,
	parameter int FRAC_BITS = COEF_FRAC_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          shift_up,
	input  logic signed [MUL_A_WIDTH-1:0] a_op,
	input  logic signed [B_WIDTH-1:0]     b_op,
	output mac_stat_t                     stat,
	output logic signed [RES_WIDTH-1:0]   result
);

	localparam int NDIG = B_WIDTH / DIGIT_WIDTH;
	localparam int PW   = MUL_A_WIDTH + B_WIDTH;
	localparam int CNTW = (NDIG > 1) ? $clog2(NDIG) : 1;
	localparam int PRW  = MUL_A_WIDTH + DIGIT_WIDTH + 1;

	localparam logic signed [PW:0] HALF_LO = (PW+1)'(longint'(1) <<< (FRAC_BITS - 1));
	localparam logic signed [PW:0] HALF_HI = (PW+1)'(longint'(1) <<< FRAC_BITS);
	localparam logic signed [PW:0] LIM_P   = (PW+1)'(longint'(1) <<< CLAMP_EXP);
	localparam logic signed [PW:0] LIM_N   = -LIM_P;

	logic signed [MUL_A_WIDTH-1:0] a_q;
	logic        [B_WIDTH-1:0]     b_q;
	logic signed [PW-1:0]          acc_q;
	logic signed [RES_WIDTH-1:0]   res_q;
	logic        [CNTW-1:0]        cnt_q;
	logic                          first_q;
	logic                          busy_q;
	logic                          rnd_q;
	logic                          done_q;
	logic                          shup_q;

	logic        [DIGIT_WIDTH-1:0] dig;
	logic signed [DIGIT_WIDTH:0]   dig_s;
	logic signed [PRW-1:0]         prod;
	logic signed [PW-1:0]          acc_nxt;
	logic signed [PW:0]            rsum;
	logic signed [PW:0]            rsh;
	logic signed [RES_WIDTH-1:0]   rcl;

	// most significant digit first, top digit signed
	assign dig     = b_q[B_WIDTH-1 -: DIGIT_WIDTH];
	assign dig_s   = first_q ? signed'({dig[DIGIT_WIDTH-1], dig}) : signed'({1'b0, dig});
	assign prod    = a_q * dig_s;
	assign acc_nxt = (acc_q <<< DIGIT_WIDTH) + PW'(prod);

	always_comb begin
		rsum = (PW+1)'(acc_q) + (shup_q ? HALF_HI : HALF_LO);
		rsh  = shup_q ? (rsum >>> (FRAC_BITS + 1)) : (rsum >>> FRAC_BITS);
		if (rsh > LIM_P) begin
			rcl = RES_WIDTH'(LIM_P);
		end else if (rsh < LIM_N) begin
			rcl = RES_WIDTH'(LIM_N);
		end else begin
			rcl = RES_WIDTH'(rsh);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			rnd_q   <= 1'b0;
			done_q  <= 1'b0;
			first_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			rnd_q  <= busy_q && (cnt_q == '0);
			done_q <= rnd_q;
			if (start) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
				cnt_q   <= CNTW'(NDIG - 1);
			end else if (busy_q) begin
				first_q <= 1'b0;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a_op;
			b_q    <= b_op;
			acc_q  <= '0;
			shup_q <= shift_up;
		end else if (busy_q) begin
			acc_q <= acc_nxt;
			b_q   <= b_q << DIGIT_WIDTH;
		end
		if (rnd_q) begin
			res_q <= rcl;
		end
	end

	assign stat.busy = busy_q | rnd_q;
	assign stat.done = done_q;
	assign result    = res_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q && !rnd_q && !done_q)
		else $error("multiplier started while still working");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("multiplier done held for more than one cycle");

endmodule

### design/sinf_seq.sv
// ----------------------------------------------------------------------------
// sinf_seq
// Sequencer: walks the coefficient product and the four products of each
// channel through the shared multiplier, then hands the pair to the output.
// ----------------------------------------------------------------------------
module sinf_seq import sinf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_free,
	input  mac_stat_t mac_stat,
	output seq_ctrl_t ctrl
);

	seq_state_t state_q;
	seq_state_t state_nxt;
	mac_op_t    op_q;
	logic       chan_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_ISSUE;
			end
			ST_ISSUE: begin
				state_nxt = ST_WAIT;
			end
			ST_WAIT: begin
				if (mac_stat.done) state_nxt = (op_q == OP_T3) ? ST_COMMIT : ST_ISSUE;
			end
			ST_COMMIT: begin
				state_nxt = chan_q ? ST_PUSH : ST_ISSUE;
			end
			ST_PUSH: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl.in_ready  = (state_q == ST_IDLE);
		ctrl.mac_start = (state_q == ST_ISSUE);
		ctrl.capture   = (state_q == ST_WAIT) && mac_stat.done;
		ctrl.commit    = (state_q == ST_COMMIT);
		ctrl.push      = (state_q == ST_PUSH) && out_free;
		ctrl.op        = op_q;
		ctrl.chan      = chan_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_CF;
			chan_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q   <= OP_CF;
						chan_q <= 1'b0;
					end
				end
				ST_WAIT: begin
					if (mac_stat.done) begin
						case (op_q)
							OP_CF:   op_q <= OP_P1;
							OP_P1:   op_q <= OP_T1;
							OP_T1:   op_q <= OP_T2;
							OP_T2:   op_q <= OP_T3;
							default: op_q <= op_q;
						endcase
					end
				end
				ST_COMMIT: begin
					if (!chan_q) begin
						op_q   <= OP_P1;
						chan_q <= 1'b1;
					end
				end
				default: begin
					op_q <= op_q;
				end
			endcase
		end
	end

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mac_stat.done |-> state_q == ST_WAIT)
		else $error("multiplier result arrived outside the wait state");

	a_commit_after_t3: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COMMIT |-> op_q == OP_T3 && !mac_stat.busy)
		else $error("channel committed before its last product");

endmodule

### design/stereo_iir_notch_filter.sv
// ----------------------------------------------------------------------------
// stereo_iir_notch_filter
// Second-order IIR notch applied to both channels of a stereo sample pair.
//
// Input channel: in_valid/in_ready with left_sample and right_sample. Output
// channel: out_valid/out_ready with left_filtered and right_filtered, one
// pair per input item. Coefficients alpha (index 0) and beta (index 1) are
// written through cfg_write/cfg_index/cfg_data; the user must do so only
// while the block is idle, which the block itself does not enforce. Each
// item takes nine products on one shared 32x17 multiplier, each an issue,
// NDIG digit passes (NDIG = 3 at the default widths), a round and a
// hand-back; a new item is taken only once the last one is handed on.
// in_ready is high only while no item is in work. Reset clears the delay
// lines and loads the default coefficients. A stalled receiver holds the
// result in the output register; the next item is accepted meanwhile and
// waits before its hand-off until the output register is free.
// ----------------------------------------------------------------------------
module stereo_iir_notch_filter import sinf_pkg::*; #(
	parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
	input  logic [COEF_WIDTH-1:0]          cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] left_sample,
	input  logic signed [SAMPLE_WIDTH-1:0] right_sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] left_filtered,
	output logic signed [SAMPLE_WIDTH-1:0] right_filtered
);

	localparam int SW   = SAMPLE_WIDTH;
	localparam int F    = COEF_FRAC_BITS;
	localparam int VW   = SW + 33 - F;
	localparam int CFW  = 64 - F;
	localparam int BW0  = (VW > CFW) ? VW : CFW;
	localparam int BW   = (BW0 > MUL_A_WIDTH) ? BW0 : MUL_A_WIDTH;
	localparam int NDIG = (BW + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
	localparam int BPW  = NDIG * DIGIT_WIDTH;
	localparam int SUMW = RES_WIDTH + 1;
	localparam int RS   = 30 - F;

	localparam logic signed [COEF_WIDTH-1:0] ALPHA_RST =
		COEF_WIDTH'((ALPHA_RESET_Q30 + ((longint'(1) <<< RS) >>> 1)) >>> RS);
	localparam logic signed [COEF_WIDTH-1:0] BETA_RST =
		COEF_WIDTH'((BETA_RESET_Q30 + ((longint'(1) <<< RS) >>> 1)) >>> RS);
	localparam logic signed [MUL_A_WIDTH-1:0] ONE = MUL_A_WIDTH'(longint'(1) <<< F);
	localparam logic signed [SUMW-1:0] SMAX = SUMW'((longint'(1) <<< (SW - 1)) - 1);
	localparam logic signed [SUMW-1:0] SMIN = -SMAX - 1;

	seq_ctrl_t ctrl;
	mac_stat_t mac_stat;

	logic signed [COEF_WIDTH-1:0]  alpha_q;
	logic signed [COEF_WIDTH-1:0]  beta_q;
	logic signed [SW-1:0]          xin_q [2];
	logic signed [SW-1:0]          x1_q [2];
	logic signed [SW-1:0]          x2_q [2];
	logic signed [SW-1:0]          y1_q [2];
	logic signed [SW-1:0]          y2_q [2];
	logic signed [BPW-1:0]         v_q;
	logic signed [BPW-1:0]         cf_q;
	logic signed [SUMW-1:0]        sum_q;
	logic signed [SW-1:0]          left_q;
	logic signed [SW-1:0]          right_q;
	logic                          out_valid_q;

	logic                          out_free;
	logic signed [MUL_A_WIDTH-1:0] ga;
	logic signed [MUL_A_WIDTH-1:0] a_op;
	logic signed [BPW-1:0]         b_op;
	logic                          shift_up;
	logic signed [RES_WIDTH-1:0]   mac_res;
	logic signed [SUMW-1:0]        vfull;
	logic signed [SW-1:0]          ysat;

	assign out_free = !out_valid_q || out_ready;
	assign ga       = ONE + MUL_A_WIDTH'(alpha_q);

	sinf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.mac_stat (mac_stat),
		.ctrl     (ctrl)
	);

	always_comb begin
		shift_up = 1'b0;
		case (ctrl.op)
			OP_CF: begin
				a_op = ga;
				b_op = BPW'(beta_q);
			end
			OP_P1: begin
				a_op = MUL_A_WIDTH'(signed'({beta_q, 1'b0}));
				b_op = BPW'(x1_q[ctrl.chan]);
			end
			OP_T1: begin
				a_op     = ga;
				b_op     = v_q;
				shift_up = 1'b1;
			end
			OP_T2: begin
				a_op = MUL_A_WIDTH'(y1_q[ctrl.chan]);
				b_op = cf_q;
			end
			OP_T3: begin
				a_op = MUL_A_WIDTH'(y2_q[ctrl.chan]);
				b_op = BPW'(alpha_q);
			end
			default: begin
				a_op = ga;
				b_op = BPW'(beta_q);
			end
		endcase
	end

	sinf_mac #(
		.B_WIDTH   (BPW),
		.FRAC_BITS (F)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.mac_start),
		.shift_up (shift_up),
		.a_op     (a_op),
		.b_op     (b_op),
		.stat     (mac_stat),
		.result   (mac_res)
	);

	assign vfull = SUMW'(xin_q[ctrl.chan]) - SUMW'(mac_res) + SUMW'(x2_q[ctrl.chan]);

	always_comb begin
		if (sum_q > SMAX) begin
			ysat = SW'(SMAX);
		end else if (sum_q < SMIN) begin
			ysat = SW'(SMIN);
		end else begin
			ysat = SW'(sum_q);
		end
	end

	// coefficients, delay lines and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= ALPHA_RST;
			beta_q      <= BETA_RST;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				x1_q[i] <= '0;
				x2_q[i] <= '0;
				y1_q[i] <= '0;
				y2_q[i] <= '0;
			end
		end else begin
			if (cfg_write && cfg_index == REG_ALPHA) alpha_q <= cfg_data;
			if (cfg_write && cfg_index == REG_BETA) beta_q <= cfg_data;
			if (ctrl.commit) begin
				x2_q[ctrl.chan] <= x1_q[ctrl.chan];
				x1_q[ctrl.chan] <= xin_q[ctrl.chan];
				y2_q[ctrl.chan] <= y1_q[ctrl.chan];
				y1_q[ctrl.chan] <= ysat;
			end
			if (ctrl.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working values of the item in flight
	always_ff @(posedge clk) begin
		if (in_valid && ctrl.in_ready) begin
			xin_q[0] <= left_sample;
			xin_q[1] <= right_sample;
		end
		if (ctrl.capture) begin
			case (ctrl.op)
				OP_CF:   cf_q  <= BPW'(mac_res);
				OP_P1:   v_q   <= BPW'(vfull);
				OP_T1:   sum_q <= SUMW'(mac_res);
				OP_T2:   sum_q <= sum_q + SUMW'(mac_res);
				OP_T3:   sum_q <= sum_q - SUMW'(mac_res);
				default: sum_q <= sum_q;
			endcase
		end
		if (ctrl.push) begin
			left_q  <= y1_q[0];
			right_q <= y1_q[1];
		end
	end

	assign in_ready       = ctrl.in_ready;
	assign out_valid      = out_valid_q;
	assign left_filtered  = left_q;
	assign right_filtered = right_q;

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |-> !out_valid_q || out_ready)
		else $error("result pushed over an item not yet taken");

endmodule
